// ===== rtl/core/dual_wheel_quadrature_pi_speed_control_unit_assert.svh =====
// Assertion macros shared by the speed control RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef DUAL_WHEEL_QUADRATURE_PI_SPEED_CONTROL_UNIT_ASSERT_SVH
`define DUAL_WHEEL_QUADRATURE_PI_SPEED_CONTROL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DWQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DWQ_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DWQ_ASSERT(lbl, prop, msg)
`define DWQ_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/core/dwqpi_pkg.sv =====
// Types, constants and helper functions of the dual wheel speed controller.
// No dependencies; the front end, queue, back end and top module import this package.
package dwqpi_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int PULSE_WIDTH = 16;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = 1;
  localparam int MUL_A_W     = 34;
  localparam int MUL_B_W     = 33;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int WIDE_W      = PROD_W + 1;
  localparam int T_W         = PROD_W - FRAC_BITS;
  localparam int DIV_STEPS   = 16;
  localparam int DIV_CNT_W   = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic signed [PULSE_WIDTH:0] PULSE_MAX =
    $signed((PULSE_WIDTH+1)'((64'd1 << (PULSE_WIDTH-1)) - 64'd1));
  // The bitwise complement of the largest value is the most negative one.
  localparam logic signed [PULSE_WIDTH:0] PULSE_MIN = ~PULSE_MAX;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(64'sd2147483647);
  localparam logic signed [WIDE_W-1:0] SAT_MIN = ~SAT_MAX;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PWM_PERIOD, REG_SPEED_SCALE, REG_REF_SCALE, REG_GAIN_G,
    REG_GAIN_CG, REG_ANTIWINDUP_GAIN, REG_SPEED_LIMIT, REG_BRAKE_DELAY
  } cfg_reg_t;

  localparam logic [15:0] RST_PWM_PERIOD      = 16'd1000;
  localparam logic [31:0] RST_SPEED_SCALE     = 32'd65536;
  localparam logic [31:0] RST_REF_SCALE       = 32'd230031;
  localparam logic [31:0] RST_GAIN_G          = 32'd65536;
  localparam logic [31:0] RST_GAIN_CG         = 32'd0;
  localparam logic [31:0] RST_ANTIWINDUP_GAIN = 32'd0;
  localparam logic [30:0] RST_SPEED_LIMIT     = 31'd655360;
  localparam logic [15:0] RST_BRAKE_DELAY     = 16'd75;

  typedef struct packed {
    logic [15:0] pwm_period;
    logic [31:0] speed_scale;
    logic [31:0] ref_scale;
    logic [31:0] gain_g;
    logic [31:0] gain_cg;
    logic [31:0] antiwindup_gain;
    logic [30:0] speed_limit;
    logic [15:0] brake_delay;
  } cfg_t;

  typedef enum logic {ITEM_SAMPLE = 1'b0, ITEM_CONTROL = 1'b1} item_kind_t;

  typedef struct packed {
    item_kind_t        kind;
    logic signed [2:0] d_left;
    logic signed [2:0] d_right;
    logic signed [7:0] sp_left;
    logic signed [7:0] sp_right;
  } q_entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SPD, S_REF, S_ERR, S_GE, S_CGE, S_DRV,
    S_AW, S_DMUL, S_DLOAD, S_DIV, S_DONE
  } ctl_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] y;
    y = x;
    if (x > SAT_MAX) y = SAT_MAX;
    if (x < SAT_MIN) y = SAT_MIN;
    return y[31:0];
  endfunction

  // 4x quadrature decode of one wheel, counted in the left wheel's sense.
  function automatic logic signed [2:0] decode(input logic pa, input logic pb,
                                               input logic a, input logic b);
    logic signed [2:0] d;
    d = 3'sd0;
    if (!pa && a) d = b ? d + 3'sd1 : d - 3'sd1;
    if (pa && !a) d = b ? d - 3'sd1 : d + 3'sd1;
    if (!pb && b) d = a ? d - 3'sd1 : d + 3'sd1;
    if (pb && !b) d = a ? d + 3'sd1 : d - 3'sd1;
    return d;
  endfunction

endpackage

// ===== rtl/core/dwqpi_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Stand-alone; payload widths follow the item fields.
interface dwqpi_in_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic              a_left;
  logic              b_left;
  logic              a_right;
  logic              b_right;
  logic signed [7:0] setpoint_left;
  logic signed [7:0] setpoint_right;
  modport source (output valid, cmd, a_left, b_left, a_right, b_right,
                  setpoint_left, setpoint_right, input ready);
  modport sink (input valid, cmd, a_left, b_left, a_right, b_right,
                setpoint_left, setpoint_right, output ready);
endinterface

interface dwqpi_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        duty_left;
  logic [15:0]        duty_right;
  logic               brake_on;
  logic               brake_timing;
  logic signed [31:0] position_left;
  logic signed [31:0] position_right;
  modport source (output valid, duty_left, duty_right, brake_on, brake_timing,
                  position_left, position_right, input ready);
  modport sink (input valid, duty_left, duty_right, brake_on, brake_timing,
                position_left, position_right, output ready);
endinterface

// ===== rtl/core/dual_wheel_quadrature_pi_speed_control_unit.sv =====
// Two-wheel quadrature decoder and incremental PI speed controller. Every
// accepted beat yields one result beat. A control tick with a nonzero
// setpoint runs nine sequenced steps per wheel, using the one shared 34x33
// multiplier, and a 16-step radix-2 duty divider. A two-entry queue lets
// the input side keep accepting beats while the back end works, and the
// result register lets the back end finish while a result beat is still
// waiting.
module dual_wheel_quadrature_pi_speed_control_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  dwqpi_in_if.sink                         in_ch,
  dwqpi_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [dwqpi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dwqpi_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dwqpi_pkg::*;

  cfg_t     cfg_r;
  q_entry_t q_wr, q_rd;
  logic     q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_period      <= RST_PWM_PERIOD;
      cfg_r.speed_scale     <= RST_SPEED_SCALE;
      cfg_r.ref_scale       <= RST_REF_SCALE;
      cfg_r.gain_g          <= RST_GAIN_G;
      cfg_r.gain_cg         <= RST_GAIN_CG;
      cfg_r.antiwindup_gain <= RST_ANTIWINDUP_GAIN;
      cfg_r.speed_limit     <= RST_SPEED_LIMIT;
      cfg_r.brake_delay     <= RST_BRAKE_DELAY;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PWM_PERIOD:      cfg_r.pwm_period      <= cfg_wdata[15:0];
        REG_SPEED_SCALE:     cfg_r.speed_scale     <= cfg_wdata;
        REG_REF_SCALE:       cfg_r.ref_scale       <= cfg_wdata;
        REG_GAIN_G:          cfg_r.gain_g          <= cfg_wdata;
        REG_GAIN_CG:         cfg_r.gain_cg         <= cfg_wdata;
        REG_ANTIWINDUP_GAIN: cfg_r.antiwindup_gain <= cfg_wdata;
        REG_SPEED_LIMIT:     cfg_r.speed_limit     <= cfg_wdata[30:0];
        REG_BRAKE_DELAY:     cfg_r.brake_delay     <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  dwqpi_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr)
  );

  dwqpi_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  dwqpi_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_data  (q_rd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );
endmodule

// ===== rtl/core/dwqpi_front.sv =====
// Front end: accepts input beats, decodes encoder edges and queues work items.
// Depends on dwqpi_pkg and dwqpi_in_if.
module dwqpi_front (
  input  logic               clk,
  input  logic               rst_n,
  dwqpi_in_if.sink           in_ch,
  input  logic               q_full,
  output logic               q_push,
  output dwqpi_pkg::q_entry_t q_data
);
  import dwqpi_pkg::*;

  logic [3:0] prev_pins_r, prev_pins_nxt;
  logic       take;

  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && !q_full;
  assign q_push      = take;

  always_comb begin
    q_data.kind     = item_kind_t'(in_ch.cmd);
    q_data.d_left   = decode(prev_pins_r[0], prev_pins_r[1], in_ch.a_left, in_ch.b_left);
    // The right wheel is mounted mirrored, so it counts the other way.
    q_data.d_right  = -decode(prev_pins_r[2], prev_pins_r[3], in_ch.a_right, in_ch.b_right);
    q_data.sp_left  = in_ch.setpoint_left;
    q_data.sp_right = in_ch.setpoint_right;
  end

  always_comb begin
    prev_pins_nxt = prev_pins_r;
    if (take && !in_ch.cmd) begin
      prev_pins_nxt = {in_ch.b_right, in_ch.a_right, in_ch.b_left, in_ch.a_left};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pins_r <= '0;
    end else begin
      prev_pins_r <= prev_pins_nxt;
    end
  end
endmodule

// ===== rtl/core/dwqpi_fifo.sv =====
// Two-entry queue of classified work items between front and back end.
// Depends on dwqpi_pkg and the assertion macro header.
`include "dual_wheel_quadrature_pi_speed_control_unit_assert.svh"
module dwqpi_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dwqpi_pkg::q_entry_t wr_data,
  input  logic                pop,
  output dwqpi_pkg::q_entry_t rd_data,
  output logic                full,
  output logic                empty
);
  import dwqpi_pkg::*;

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  `DWQ_NEVER(a_q_overflow, push && full, "queue written while full")
  `DWQ_NEVER(a_q_underflow, pop && empty, "queue read while empty")
  `DWQ_ASSERT(a_q_count, cnt_r <= (QPTR_W+1)'(QDEPTH), "queue count beyond depth")
endmodule

// ===== rtl/core/dwqpi_back.sv =====
// Back end: pulse accumulation, brake timer and the sequenced PI step of both
// wheels on one shared multiplier and a radix-2 duty divider. Depends on
// dwqpi_pkg, dwqpi_out_if and the assertion macro header.
`include "dual_wheel_quadrature_pi_speed_control_unit_assert.svh"
module dwqpi_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dwqpi_pkg::cfg_t     cfg,
  input  logic                q_empty,
  input  dwqpi_pkg::q_entry_t q_data,
  output logic                q_pop,
  dwqpi_out_if.source         out_ch
);
  import dwqpi_pkg::*;

  ctl_state_t state_r, state_nxt;

  logic                          wheel_r, wheel_nxt;
  q_entry_t                      item_r, item_nxt;
  logic signed [PULSE_WIDTH-1:0] pulse_r [2], pulse_nxt [2];
  logic signed [31:0]            perr_r [2], perr_nxt [2];
  logic signed [31:0]            pdrv_r [2], pdrv_nxt [2];
  logic signed [31:0]            wind_r [2], wind_nxt [2];
  logic signed [31:0]            pos_r [2], pos_nxt [2];
  logic [15:0]                   duty_r [2], duty_nxt [2];
  logic [15:0]                   brake_cnt_r, brake_cnt_nxt;
  logic                          brake_flag_r, brake_flag_nxt;
  logic signed [31:0]            speed_r, speed_nxt;
  logic signed [31:0]            e_r, e_nxt;
  logic signed [T_W-1:0]         t_r, t_nxt;
  logic signed [31:0]            u_r, u_nxt;
  logic signed [31:0]            s_r, s_nxt;
  logic signed [PROD_W-1:0]      prod_r, prod_nxt;
  logic [31:0]                   rem_r, rem_nxt;
  logic [DIV_STEPS-1:0]          quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0]          div_cnt_r, div_cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        o_duty_l_r, o_duty_r_r;
  logic               o_brake_r, o_timing_r;
  logic signed [31:0] o_pos_l_r, o_pos_r_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic [30:0]               lim;
  logic signed [31:0]        lim_s;
  logic [14:0]               half;
  logic                      out_free;
  logic                      div_last;
  logic signed [7:0]         sp_w;
  logic                      zero_cmd;
  logic [16:0]               cnt_inc;
  logic signed [PULSE_WIDTH:0] psum_l, psum_r;
  logic signed [31:0]        ref_v, u_v;
  logic [32:0]               trial, diff;
  logic                      ge;

  assign lim      = (cfg.speed_limit == '0) ? 31'd1 : cfg.speed_limit;
  assign lim_s    = $signed({1'b0, lim});
  assign half     = cfg.pwm_period[15:1];
  assign out_free = !out_valid_r || out_ch.ready;
  assign div_last = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign sp_w     = wheel_r ? item_r.sp_right : item_r.sp_left;
  assign zero_cmd = (q_data.sp_left == '0) && (q_data.sp_right == '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          if (q_data.kind == ITEM_SAMPLE || zero_cmd) state_nxt = S_DONE;
          else                                         state_nxt = S_SPD;
        end
      end
      S_SPD:   state_nxt = S_REF;
      S_REF:   state_nxt = S_ERR;
      S_ERR:   state_nxt = S_GE;
      S_GE:    state_nxt = S_CGE;
      S_CGE:   state_nxt = S_DRV;
      S_DRV:   state_nxt = S_AW;
      S_AW:    state_nxt = S_DMUL;
      S_DMUL:  state_nxt = S_DLOAD;
      S_DLOAD: state_nxt = S_DIV;
      S_DIV: begin
        if (div_last) state_nxt = wheel_r ? S_DONE : S_SPD;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Shared multiplier: operands picked by the step, product registered.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SPD: begin
        mul_a = MUL_A_W'(pulse_r[wheel_r]);
        mul_b = $signed(MUL_B_W'(cfg.speed_scale));
      end
      S_REF: begin
        mul_a = MUL_A_W'(sp_w);
        mul_b = $signed(MUL_B_W'(cfg.ref_scale));
      end
      S_GE: begin
        mul_a = MUL_A_W'(e_r);
        mul_b = $signed(MUL_B_W'(cfg.gain_g));
      end
      S_CGE: begin
        mul_a = MUL_A_W'(perr_r[wheel_r]);
        mul_b = $signed(MUL_B_W'(cfg.gain_cg));
      end
      S_AW: begin
        mul_a = MUL_A_W'(u_r) - MUL_A_W'(s_r);
        mul_b = $signed(MUL_B_W'(cfg.antiwindup_gain));
      end
      S_DMUL: begin
        mul_a = MUL_A_W'(s_r) + $signed(MUL_A_W'(lim));
        mul_b = $signed(MUL_B_W'(half));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Outputs and datapath of each step.
  always_comb begin
    q_pop          = 1'b0;
    wheel_nxt      = wheel_r;
    item_nxt       = item_r;
    pulse_nxt      = pulse_r;
    perr_nxt       = perr_r;
    pdrv_nxt       = pdrv_r;
    wind_nxt       = wind_r;
    pos_nxt        = pos_r;
    duty_nxt       = duty_r;
    brake_cnt_nxt  = brake_cnt_r;
    brake_flag_nxt = brake_flag_r;
    speed_nxt      = speed_r;
    e_nxt          = e_r;
    t_nxt          = t_r;
    u_nxt          = u_r;
    s_nxt          = s_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    div_cnt_nxt    = div_cnt_r;
    cnt_inc        = {1'b0, brake_cnt_r} + 17'd1;
    psum_l         = (PULSE_WIDTH+1)'(pulse_r[0]) + (PULSE_WIDTH+1)'(q_data.d_left);
    psum_r         = (PULSE_WIDTH+1)'(pulse_r[1]) + (PULSE_WIDTH+1)'(q_data.d_right);
    ref_v          = sat32(WIDE_W'(prod_r));
    u_v            = sat32(WIDE_W'(t_r) - WIDE_W'(prod_r >>> FRAC_BITS)
                           + WIDE_W'(pdrv_r[wheel_r]));
    trial          = {rem_r, quo_r[DIV_STEPS-1]};
    diff           = trial - {2'b00, lim};
    ge             = (trial >= {2'b00, lim});

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          item_nxt = q_data;
          if (q_data.kind == ITEM_SAMPLE) begin
            if (psum_l > PULSE_MAX)      pulse_nxt[0] = PULSE_MAX[PULSE_WIDTH-1:0];
            else if (psum_l < PULSE_MIN) pulse_nxt[0] = PULSE_MIN[PULSE_WIDTH-1:0];
            else                         pulse_nxt[0] = psum_l[PULSE_WIDTH-1:0];
            if (psum_r > PULSE_MAX)      pulse_nxt[1] = PULSE_MAX[PULSE_WIDTH-1:0];
            else if (psum_r < PULSE_MIN) pulse_nxt[1] = PULSE_MIN[PULSE_WIDTH-1:0];
            else                         pulse_nxt[1] = psum_r[PULSE_WIDTH-1:0];
          end else if (zero_cmd) begin
            duty_nxt[0] = {1'b0, half};
            duty_nxt[1] = {1'b0, half};
            if (!brake_flag_r) begin
              if (cnt_inc >= {1'b0, cfg.brake_delay}) begin
                brake_flag_nxt = 1'b1;
                brake_cnt_nxt  = '0;
              end else begin
                brake_cnt_nxt = cnt_inc[15:0];
              end
            end
          end else begin
            brake_cnt_nxt  = '0;
            brake_flag_nxt = 1'b0;
            wheel_nxt      = 1'b0;
          end
        end
      end
      S_REF: speed_nxt = sat32(WIDE_W'(prod_r >>> FRAC_BITS));
      S_ERR: begin
        e_nxt = sat32(WIDE_W'(ref_v) - WIDE_W'(speed_r) - WIDE_W'(wind_r[wheel_r]));
        pos_nxt[wheel_r]   = pos_r[wheel_r] + 32'(pulse_r[wheel_r]);
        pulse_nxt[wheel_r] = '0;
      end
      S_CGE: t_nxt = T_W'(prod_r >>> FRAC_BITS);
      S_DRV: begin
        u_nxt = u_v;
        if (u_v > lim_s)       s_nxt = lim_s;
        else if (u_v < -lim_s) s_nxt = -lim_s;
        else                   s_nxt = u_v;
        perr_nxt[wheel_r] = e_r;
        pdrv_nxt[wheel_r] = u_v;
      end
      S_DMUL: wind_nxt[wheel_r] = sat32(WIDE_W'(prod_r >>> FRAC_BITS));
      S_DLOAD: begin
        // The quotient stays below 2^16, so the upper part is already below
        // the divisor and only the low bits need to be shifted through.
        rem_nxt     = prod_r[DIV_STEPS+31:DIV_STEPS];
        quo_nxt     = prod_r[DIV_STEPS-1:0];
        div_cnt_nxt = '0;
      end
      S_DIV: begin
        rem_nxt     = ge ? diff[31:0] : trial[31:0];
        quo_nxt     = {quo_r[DIV_STEPS-2:0], ge};
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_last) begin
          duty_nxt[wheel_r] = 16'({quo_r[DIV_STEPS-2:0], ge});
          wheel_nxt         = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (state_r == S_DONE && out_free) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wheel_r      <= 1'b0;
      pulse_r      <= '{default: '0};
      perr_r       <= '{default: '0};
      pdrv_r       <= '{default: '0};
      wind_r       <= '{default: '0};
      pos_r        <= '{default: '0};
      duty_r       <= '{default: '0};
      brake_cnt_r  <= '0;
      brake_flag_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wheel_r      <= wheel_nxt;
      pulse_r      <= pulse_nxt;
      perr_r       <= perr_nxt;
      pdrv_r       <= pdrv_nxt;
      wind_r       <= wind_nxt;
      pos_r        <= pos_nxt;
      duty_r       <= duty_nxt;
      brake_cnt_r  <= brake_cnt_nxt;
      brake_flag_r <= brake_flag_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    speed_r   <= speed_nxt;
    e_r       <= e_nxt;
    t_r       <= t_nxt;
    u_r       <= u_nxt;
    s_r       <= s_nxt;
    prod_r    <= prod_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    div_cnt_r <= div_cnt_nxt;
    if (state_r == S_DONE && out_free) begin
      o_duty_l_r <= duty_r[0];
      o_duty_r_r <= duty_r[1];
      o_brake_r  <= brake_flag_r;
      o_timing_r <= (brake_cnt_r != '0) && !brake_flag_r;
      o_pos_l_r  <= pos_r[0];
      o_pos_r_r  <= pos_r[1];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.duty_left      = o_duty_l_r;
  assign out_ch.duty_right     = o_duty_r_r;
  assign out_ch.brake_on       = o_brake_r;
  assign out_ch.brake_timing   = o_timing_r;
  assign out_ch.position_left  = o_pos_l_r;
  assign out_ch.position_right = o_pos_r_r;

  `DWQ_ASSERT(a_brake_cnt_clear, brake_flag_r |-> (brake_cnt_r == '0), "brake count left set")
  `DWQ_ASSERT(a_ctrl_steps, (state_r != S_IDLE && state_r != S_DONE) |-> (item_r.kind == ITEM_CONTROL), "PI step on a sample")
  `DWQ_ASSERT(a_result_held, (out_valid_r && !out_ch.ready) |=> out_valid_r, "result dropped")
endmodule
